@@ rtl/core/dpb_pkg.sv @@
`default_nettype none
package dpb_pkg;

    // Table geometry: budgets 0..MAX_CAP, one stored column per loaded item.
    localparam int MAX_CAP   = 1023;
    localparam int MAX_ITEMS = 32;
    localparam int CAP_W     = 10;
    localparam int IDX_W     = 5;
    localparam int CNT_W     = 6;
    localparam int ADDR_W    = IDX_W + CAP_W;

    // One queued item as classified by the front end.
    typedef struct packed {
        logic [CAP_W-1:0] dur;
        logic             last;
        logic             store;
        logic [CNT_W-1:0] cnt;
        logic             ovf;
    } item_t;

    // One result beat.
    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [CAP_W-1:0] dur;
        logic             chosen;
        logic [CAP_W-1:0] best;
        logic             ovf;
        logic             last;
    } res_t;

endpackage
`default_nettype wire

@@ rtl/core/dpb_front.sv @@
`default_nettype none
module dpb_front import dpb_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [CAP_W-1:0] in_dur,
    input  wire logic             in_last,
    output logic                  push_valid,
    input  wire logic             push_ready,
    output item_t                 push_item
);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic             store;
    logic [CNT_W-1:0] cnt_after;

    // Classify: keep the item while the table has a free column.
    assign store     = (cnt_reg < CNT_W'(MAX_ITEMS));
    assign cnt_after = store ? cnt_reg + CNT_W'(1) : cnt_reg;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;

    always_comb begin
        push_item.dur   = in_dur;
        push_item.last  = in_last;
        push_item.store = store;
        push_item.cnt   = cnt_after;
        push_item.ovf   = ovf_reg | ~store;
    end

    // Set bookkeeping restarts after the last beat of a set.
    always_comb begin
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        if (in_valid && push_ready) begin
            if (in_last) begin
                cnt_next = '0;
                ovf_next = 1'b0;
            end else begin
                cnt_next = cnt_after;
                ovf_next = ovf_reg | ~store;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/dpb_fifo.sv @@
`default_nettype none
module dpb_fifo import dpb_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  wr_valid,
    output logic       wr_ready,
    input  item_t      wr_item,
    output logic       rd_valid,
    input  wire logic  rd_ready,
    output item_t      rd_item
);

    // Two-entry queue between front and back.
    item_t      mem [0:1];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_wr, do_rd;

    assign wr_ready = (fill_reg != 2'd2);
    assign rd_valid = (fill_reg != 2'd0);
    assign rd_item  = mem[rp_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wp_next   = do_wr ? ~wp_reg : wp_reg;
        rp_next   = do_rd ? ~rp_reg : rp_reg;
        fill_next = fill_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wp_reg] <= wr_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            fill_reg <= 2'd0;
        end else begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            fill_reg <= fill_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/dpb_back.sv @@
`default_nettype none
module dpb_back import dpb_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             q_valid,
    output logic                  q_ready,
    input  item_t                 q_item,
    input  wire logic [CAP_W-1:0] capacity,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output res_t                  res
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_FILL, ST_FILL_END, ST_BT_RD, ST_BT_CMP, ST_EMIT_RD, ST_EMIT_OUT
    } state_t;

    state_t               state_reg, state_next;
    logic [CAP_W-1:0]     dur_reg, dur_next;
    logic                 last_reg, last_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 ovf_reg, ovf_next;
    logic [CAP_W-1:0]     b_reg, b_next;
    logic [CNT_W-1:0]     j_reg, j_next;
    logic [CAP_W-1:0]     budget_reg, budget_next;
    logic [CAP_W-1:0]     best_reg, best_next;
    logic                 first_reg, first_next;
    logic [MAX_ITEMS-1:0] pick_reg, pick_next;
    logic [IDX_W-1:0]     e_reg, e_next;
    logic                 out_valid_reg, out_valid_next;
    res_t                 out_reg, out_next;

    // Fill pipeline stage between table read and table write.
    logic             s1_valid_reg, s1_valid_next;
    logic [CAP_W-1:0] s1_b_reg, s1_b_next;
    logic             s1_fit_reg, s1_fit_next;

    // Best-sum table, columns 1..MAX_ITEMS; column zero reads as zero.
    logic [CAP_W-1:0]  tbl_mem [0:(MAX_ITEMS*(MAX_CAP+1))-1];
    logic [ADDR_W-1:0] rd_a_addr, rd_b_addr, wr_addr;
    logic              zb_next;
    logic [CAP_W-1:0]  q_a_reg, q_b_reg;
    logic              zb_reg;
    logic              wr_en;
    logic [CAP_W-1:0]  wr_data;

    // Duration store, one entry per column.
    logic [CAP_W-1:0] dstore [0:MAX_ITEMS-1];
    logic [IDX_W-1:0] ds_addr;
    logic [CAP_W-1:0] dq_reg;
    logic             ds_we;

    logic [CNT_W-1:0] cnt_m1, cnt_m2, j_m1, j_m2;
    logic [CAP_W-1:0] kb, cand, db;
    logic             pop, out_free;

    function automatic logic [IDX_W-1:0] cnt_m1_of(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] t;
        t = c - CNT_W'(1);
        return t[IDX_W-1:0];
    endfunction

    assign q_ready   = (state_reg == ST_IDLE);
    assign pop       = q_valid && q_ready;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign out_free  = !out_valid_reg || res_ready;

    assign cnt_m1 = cnt_reg - CNT_W'(1);
    assign cnt_m2 = cnt_reg - CNT_W'(2);
    assign j_m1   = j_reg - CNT_W'(1);
    assign j_m2   = j_reg - CNT_W'(2);
    assign db     = b_reg - dur_reg;

    // Stage two of the fill: best of keeping and adding this duration.
    assign kb      = zb_reg ? '0 : q_b_reg;
    assign cand    = kb + dur_reg;
    assign wr_en   = s1_valid_reg;
    assign wr_addr = {cnt_m1[IDX_W-1:0], s1_b_reg};
    assign wr_data = (s1_fit_reg && (cand > (zb_reg ? '0 : q_a_reg))) ? cand
                   : (zb_reg ? '0 : q_a_reg);

    // Read address selection for table and store.
    always_comb begin
        rd_a_addr = {cnt_m2[IDX_W-1:0], b_reg};
        rd_b_addr = {cnt_m2[IDX_W-1:0], db};
        zb_next   = (cnt_reg == CNT_W'(1));
        ds_addr   = e_reg;
        if (state_reg == ST_BT_RD || state_reg == ST_BT_CMP) begin
            rd_a_addr = {j_m1[IDX_W-1:0], budget_reg};
            rd_b_addr = {j_m2[IDX_W-1:0], budget_reg};
            zb_next   = (j_reg == CNT_W'(1));
            ds_addr   = j_m1[IDX_W-1:0];
        end
    end

    assign ds_we = pop && q_item.store;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tbl_mem[wr_addr] <= wr_data;
        end
        q_a_reg <= tbl_mem[rd_a_addr];
        q_b_reg <= tbl_mem[rd_b_addr];
        zb_reg  <= zb_next;
    end

    always_ff @(posedge aclk) begin
        if (ds_we) begin
            dstore[cnt_m1_of(q_item.cnt)] <= q_item.dur;
        end
        dq_reg <= dstore[ds_addr];
    end

    // Sequencer.
    always_comb begin
        state_next     = state_reg;
        dur_next       = dur_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        b_next         = b_reg;
        j_next         = j_reg;
        budget_next    = budget_reg;
        best_next      = best_reg;
        first_next     = first_reg;
        pick_next      = pick_reg;
        e_next         = e_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !res_ready;
        s1_valid_next  = 1'b0;
        s1_b_next      = b_reg;
        s1_fit_next    = (b_reg != '0) && (dur_reg <= b_reg);

        case (state_reg)
            ST_IDLE: begin
                if (pop) begin
                    dur_next  = q_item.dur;
                    last_next = q_item.last;
                    cnt_next  = q_item.cnt;
                    ovf_next  = q_item.ovf;
                    b_next    = '0;
                    if (q_item.store) begin
                        state_next = ST_FILL;
                    end else if (q_item.last && q_item.cnt != '0) begin
                        j_next      = q_item.cnt;
                        budget_next = capacity;
                        first_next  = 1'b1;
                        pick_next   = '0;
                        state_next  = ST_BT_RD;
                    end
                end
            end
            ST_FILL: begin
                s1_valid_next = 1'b1;
                b_next        = b_reg + CAP_W'(1);
                if (b_reg == CAP_W'(MAX_CAP)) begin
                    state_next = ST_FILL_END;
                end
            end
            ST_FILL_END: begin
                if (last_reg) begin
                    j_next      = cnt_reg;
                    budget_next = capacity;
                    first_next  = 1'b1;
                    pick_next   = '0;
                    state_next  = ST_BT_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_BT_RD: begin
                state_next = ST_BT_CMP;
            end
            ST_BT_CMP: begin
                first_next = 1'b0;
                if (first_reg) begin
                    best_next = q_a_reg;
                end
                if (kb < q_a_reg) begin
                    pick_next[j_m1[IDX_W-1:0]] = 1'b1;
                    budget_next = (dq_reg <= budget_reg) ? budget_reg - dq_reg : '0;
                end
                j_next = j_m1;
                if (j_m1 == '0) begin
                    e_next     = '0;
                    state_next = ST_EMIT_RD;
                end else begin
                    state_next = ST_BT_RD;
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_next.index = e_reg;
                    out_next.dur   = dq_reg;
                    out_next.chosen = pick_reg[e_reg];
                    out_next.best  = best_reg;
                    out_next.ovf   = ovf_reg;
                    out_next.last  = ({1'b0, e_reg} == cnt_m1);
                    e_next         = e_reg + IDX_W'(1);
                    state_next     = ({1'b0, e_reg} == cnt_m1) ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state under reset; payload registers free-running.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            s1_valid_reg  <= s1_valid_next;
        end
        dur_reg    <= dur_next;
        last_reg   <= last_next;
        cnt_reg    <= cnt_next;
        ovf_reg    <= ovf_next;
        b_reg      <= b_next;
        j_reg      <= j_next;
        budget_reg <= budget_next;
        best_reg   <= best_next;
        first_reg  <= first_next;
        pick_reg   <= pick_next;
        e_reg      <= e_next;
        out_reg    <= out_next;
        s1_b_reg   <= s1_b_next;
        s1_fit_reg <= s1_fit_next;
    end

endmodule
`default_nettype wire

@@ rtl/core/subset_sum_dp_with_backtrack.sv @@
// Each stored beat is dequeued, then fills its table column one budget per
// cycle through the two-read, one-write table memory, then drains the fill
// pipeline. A dropped beat is only dequeued. A last beat adds a backtrack with
// a read and a compare state per stored item, then a read and an output state
// per result beat; n stored items give n result beats. Input ingests up to two
// beats ahead through the queue. Reset clears control, item count, overflow
// and capacity; table column zero is implicit, so no clearing pass is needed.
`default_nettype none
module subset_sum_dp_with_backtrack import dpb_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // [9:0] duration, [15:10] zero
    input  wire logic        s_tlast,  // last_item
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,  // [4:0] event_index, [14:5] event_duration,
                                       // [15] chosen, [25:16] best_total, [26] overflow
    output logic             m_tlast,  // last_result
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [9:0]  cfg_data  // capacity
);

    logic [CAP_W-1:0] cap_reg;
    logic             push_valid, push_ready, pop_valid, pop_ready;
    item_t            push_item, pop_item;
    res_t             res;

    // Capacity register.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= '0;
        end else if (cfg_valid) begin
            cap_reg <= cfg_data;
        end
    end

    dpb_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_dur     (s_tdata[CAP_W-1:0]),
        .in_last    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    dpb_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_item  (push_item),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_item  (pop_item)
    );

    dpb_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (pop_valid),
        .q_ready   (pop_ready),
        .q_item    (pop_item),
        .capacity  (cap_reg),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // Result beat packing.
    assign m_tdata = {5'b0, res.ovf, res.best, res.chosen, res.dur, res.index};
    assign m_tlast = res.last;

endmodule
`default_nettype wire

@@ rtl/core/dpb_checker.sv @@
`default_nettype none
module dpb_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    // A stalled result beat stays offered.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // No result beat right after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat after reset");

    // Padding bits stay zero.
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:27] == 5'd0)
        else $error("nonzero padding in result");

    // A chosen event never exceeds the best total.
    a_chosen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[15] |-> m_tdata[14:5] <= m_tdata[25:16])
        else $error("chosen event exceeds best total");

endmodule

bind subset_sum_dp_with_backtrack dpb_checker u_dpb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
